### design/window_location_iterator_assert.svh
// Assertion macros shared by the window location iterator RTL.
// Stand-alone header: no package or module dependencies.
`ifndef WINDOW_LOCATION_ITERATOR_ASSERT_SVH
`define WINDOW_LOCATION_ITERATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WLI_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("window_location_iterator: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define WLI_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("window_location_iterator: next-cycle check failed");

`endif

### design/wli_pkg.sv
// Shared types, constants and helper functions of the window location iterator.
// No dependencies; imported by every module of the block.
`default_nettype none
package wli_pkg;

   localparam int NUM_DIMS   = 4;
   localparam int COORD_BITS = 16;
   localparam int SLOT_BITS  = 16;
   localparam int LOC_BITS   = 64;
   localparam int DIM_BITS   = 2;
   localparam int CNT_BITS   = 3;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int REG_IDX_BITS  = 3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [LOC_BITS-1:0]   loc_type;
   typedef logic [DIM_BITS-1:0]   dim_type;

   typedef enum logic [1:0] {
      CMD_ADVANCE = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_LOAD    = 2'd2
   } cmd_type;

   localparam logic [REG_IDX_BITS-1:0] REG_TOP_LEFT     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_BOTTOM_RIGHT = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_STEP         = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_ORDER        = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_DIMS_IN_USE  = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_STEPPED      = 3'd5;

   // Running location and carry handed from one order cell to the next outer one.
   typedef struct packed {
      loc_type loc;
      logic    carry;
      logic    ovf;
   } wli_link_type;

   // Per-cell control: which dimension the slot names and its bounds.
   typedef struct packed {
      logic      start;
      logic      is_outer;
      dim_type   dim;
      coord_type step;
      coord_type br;
      coord_type tl;
   } wli_cell_cfg_type;

   // Result waiting in the output stage; done is derived from it.
   typedef struct packed {
      loc_type loc;
      logic    ovf;
   } wli_result_type;

   function automatic coord_type slot_get(input loc_type v, input dim_type d);
      return v[SLOT_BITS*d +: COORD_BITS];
   endfunction

   function automatic loc_type clean_location(input loc_type v);
      loc_type r;
      r = '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         r[SLOT_BITS*d +: COORD_BITS] = v[SLOT_BITS*d +: COORD_BITS];
      end
      return r;
   endfunction

   // Order entry to dimension index (entry mod NUM_DIMS), as a small table.
   function automatic dim_type order_dim(input logic [1:0] e);
      dim_type r;
      case (e)
         2'd0:    r = DIM_BITS'(0 % NUM_DIMS);
         2'd1:    r = DIM_BITS'(1 % NUM_DIMS);
         2'd2:    r = DIM_BITS'(2 % NUM_DIMS);
         default: r = DIM_BITS'(3 % NUM_DIMS);
      endcase
      return r;
   endfunction

   function automatic logic walk_done(input loc_type loc, input logic ovf,
                                      input dim_type d0, input loc_type br,
                                      input logic zero_step);
      return ovf | zero_step | (slot_get(loc, d0) > slot_get(br, d0));
   endfunction

endpackage
`default_nettype wire

### design/wli_cell.sv
// One order slot of the odometer: adds the step, wraps and carries outward.
// Depends on wli_pkg.
`default_nettype none
module wli_cell import wli_pkg::*; (
   input  wli_cell_cfg_type cfg,
   input  wli_link_type     link_in,
   output wli_link_type     link_out
);

   coord_type           coord;
   logic [COORD_BITS:0] sum;
   logic                go;

   assign coord = slot_get(link_in.loc, cfg.dim);
   assign sum   = {1'b0, coord} + {1'b0, cfg.step};
   assign go    = link_in.carry | cfg.start;

   always_comb begin
      link_out       = link_in;
      link_out.carry = 1'b0;
      if (go) begin
         if (cfg.is_outer) begin
            // outermost always takes the step; wrap sets the sticky flag
            link_out.loc[SLOT_BITS*cfg.dim +: COORD_BITS] = sum[COORD_BITS-1:0];
            link_out.ovf = link_in.ovf | sum[COORD_BITS];
         end else if (sum <= {1'b0, cfg.br}) begin
            link_out.loc[SLOT_BITS*cfg.dim +: COORD_BITS] = sum[COORD_BITS-1:0];
         end else begin
            link_out.loc[SLOT_BITS*cfg.dim +: COORD_BITS] = cfg.tl;
            link_out.carry = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### design/wli_skid.sv
// Two-entry output stage (main register plus skid register) for results.
// Depends on wli_pkg.
`default_nettype none
module wli_skid import wli_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  wli_result_type push_data,
   input  logic           out_stall,
   output logic           out_valid,
   output wli_result_type out_data,
   output logic           full
);

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   wli_result_type main_data_ff, main_data_in;
   wli_result_type skid_data_ff, skid_data_in;
   logic           take;

   assign take = main_valid_ff & ~out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign full      = skid_valid_ff;

endmodule
`default_nettype wire

### design/window_location_iterator.sv
// Top level of the window location iterator: CSRs, walk state, cell chain, output stage.
// Depends on wli_pkg, wli_cell, wli_skid and window_location_iterator_assert.svh.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     req_cmd, req_load_location
//   rsp      out        rsp_valid/stall     rsp_location, rsp_done_res
//   csr      in/out     psel/penable/ready  paddr, pwdata, prdata (64-bit)
//
// One transaction per cycle while req_stall is low: every command updates the walk
// state in the cycle it is accepted, the carry rippling through one cell per order slot
// within that cycle. Its result is registered in the output stage before it reaches rsp.
// Reset (synchronous) clears the location and overflow flag and loads CSR defaults.
// While rsp is stalled, one more transaction is absorbed in the skid register;
// req_stall rises only when that register is occupied.
`default_nettype none
`include "window_location_iterator_assert.svh"
module window_location_iterator import wli_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic [LOC_BITS-1:0]      req_load_location,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LOC_BITS-1:0]      rsp_location,
   output logic                     rsp_done_res,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // ---------------------------------------------------------------- CSRs
   loc_type            top_left_ff, bottom_right_ff, step_ff;
   logic [7:0]         order_ff;
   logic [CNT_BITS-1:0] in_use_ff;
   logic               stepped_ff;
   logic               csr_write;
   logic [REG_IDX_BITS-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         top_left_ff     <= '0;
         bottom_right_ff <= '0;
         step_ff         <= 64'h0001_0001_0001_0001;
         order_ff        <= 8'hE4;
         in_use_ff       <= 3'd2;
         stepped_ff      <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_TOP_LEFT:     top_left_ff     <= csr_pwdata;
            REG_BOTTOM_RIGHT: bottom_right_ff <= csr_pwdata;
            REG_STEP:         step_ff         <= csr_pwdata;
            REG_ORDER:        order_ff        <= csr_pwdata[7:0];
            REG_DIMS_IN_USE:  in_use_ff       <= csr_pwdata[CNT_BITS-1:0];
            REG_STEPPED:      stepped_ff      <= csr_pwdata[0];
            default: ;  // unmapped: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TOP_LEFT:     csr_prdata = top_left_ff;
         REG_BOTTOM_RIGHT: csr_prdata = bottom_right_ff;
         REG_STEP:         csr_prdata = step_ff;
         REG_ORDER:        csr_prdata = {56'd0, order_ff};
         REG_DIMS_IN_USE:  csr_prdata = {{(CSR_DATA_BITS-CNT_BITS){1'b0}}, in_use_ff};
         REG_STEPPED:      csr_prdata = {63'd0, stepped_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------- derived configuration
   // Clamp the active slot count into 1..NUM_DIMS.
   logic [CNT_BITS-1:0] active_n;
   always_comb begin
      if (in_use_ff == '0) begin
         active_n = CNT_BITS'(1);
      end else if (in_use_ff > CNT_BITS'(NUM_DIMS)) begin
         active_n = CNT_BITS'(NUM_DIMS);
      end else begin
         active_n = in_use_ff;
      end
   end

   dim_type slot_dim [NUM_DIMS];
   logic    zero_step;

   always_comb begin
      for (int i = 0; i < NUM_DIMS; i++) begin
         slot_dim[i] = order_dim(order_ff[2*i +: 2]);
      end
   end

   // Stepped mode: any zero step among the active slots ends the walk.
   always_comb begin
      zero_step = 1'b0;
      for (int i = 0; i < NUM_DIMS; i++) begin
         if (CNT_BITS'(i) < active_n && slot_get(step_ff, slot_dim[i]) == '0) begin
            zero_step = stepped_ff;
         end
      end
   end

   // ------------------------------------------------------------ walk state
   loc_type loc_ff, loc_in;
   logic    ovf_ff, ovf_in;
   logic    req_accept;
   logic    done_now;

   assign req_accept = req_valid & ~req_stall;
   assign done_now   = walk_done(loc_ff, ovf_ff, slot_dim[0], bottom_right_ff, zero_step);

   // Cell chain: link[NUM_DIMS] is the current state, innermost slot starts the carry,
   // link[0] leaves the outermost cell with the advanced location.
   wli_link_type     link [NUM_DIMS+1];
   wli_cell_cfg_type cell_cfg [NUM_DIMS];

   assign link[NUM_DIMS] = '{loc: loc_ff, carry: 1'b0, ovf: 1'b0};

   for (genvar g = 0; g < NUM_DIMS; g++) begin : g_cell
      always_comb begin
         cell_cfg[g].start    = (active_n == CNT_BITS'(g + 1));
         cell_cfg[g].is_outer = (g == 0);
         cell_cfg[g].dim      = slot_dim[g];
         cell_cfg[g].step     = stepped_ff ? slot_get(step_ff, slot_dim[g])
                                           : COORD_BITS'(1);
         cell_cfg[g].br       = slot_get(bottom_right_ff, slot_dim[g]);
         cell_cfg[g].tl       = slot_get(top_left_ff, slot_dim[g]);
      end

      wli_cell u_cell (
         .cfg      (cell_cfg[g]),
         .link_in  (link[g+1]),
         .link_out (link[g])
      );
   end

   // Next state per command; unused command code holds everything.
   always_comb begin
      loc_in = loc_ff;
      ovf_in = ovf_ff;
      case (cmd_type'(req_cmd))
         CMD_ADVANCE: begin
            if (!done_now) begin
               loc_in = link[0].loc;
               ovf_in = ovf_ff | link[0].ovf;
            end
         end
         CMD_RESTART: begin
            loc_in = clean_location(top_left_ff);
            ovf_in = 1'b0;
         end
         CMD_LOAD: begin
            loc_in = clean_location(req_load_location);
            ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (req_accept) begin
         loc_ff <= loc_in;
         ovf_ff <= ovf_in;
      end
   end

   // ---------------------------------------------------------- output stage
   wli_result_type rsp_data;

   wli_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data ('{loc: loc_in, ovf: ovf_in}),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (req_stall)
   );

   // Users must hold Configuration while results are pending (not enforced); done derives from the held result.
   assign rsp_location = rsp_data.loc;
   assign rsp_done_res = walk_done(rsp_data.loc, rsp_data.ovf, slot_dim[0],
                                   bottom_right_ff, zero_step);

   // ------------------------------------------------------------ assertions
   `WLI_ASSERT_NOW(a_stall_needs_result, clock, reset, req_stall, rsp_valid)
   `WLI_ASSERT_NEXT(a_restart_clears_ovf, clock, reset,
      req_accept && req_cmd == CMD_RESTART, !ovf_ff)
   `WLI_ASSERT_NEXT(a_advance_done_holds, clock, reset,
      req_accept && req_cmd == CMD_ADVANCE && done_now, $stable(loc_ff))
   `WLI_ASSERT_NEXT(a_result_follows_accept, clock, reset, req_accept, rsp_valid)

endmodule
`default_nettype wire
